/* hdl/cffsa_pkg.sv */
// Package for the circular first-free slot allocator.
// Holds widths, operation codes, register indexes and the request/grant structs.
// No dependencies.
`default_nettype none

package cffsa_pkg;

    // Fixed field widths.
    localparam int SLOT_W     = 8;
    localparam int CNT_W      = 9;
    localparam int SLOT_REACH = 256;

    // Default built capacity.
    localparam int MAX_SLOTS_DEF = 256;

    // Register file.
    localparam int                APB_AW      = 3;
    localparam int                APB_DW      = 32;
    localparam logic              REG_SLOT_COUNT = 1'b0;
    localparam logic [CNT_W-1:0]  COUNT_RESET = 9'd256;

    // Operation codes carried in the input tuser.
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Request handed to the slot map in the cycle it is executed.
    typedef struct packed {
        logic              fire;
        logic              op;
        logic [SLOT_W-1:0] slot;
    } t_req;

    // Outcome of the search for an allocate request.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              full;
    } t_grant;

endpackage : cffsa_pkg

`default_nettype wire

/* hdl/cffsa_apb_regs.sv */
// APB register file of the slot allocator: the slot count register.
// Depends on cffsa_pkg.
`default_nettype none

module cffsa_apb_regs
    import cffsa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [APB_AW-1:0] i_paddr,
    input  wire logic [APB_DW-1:0] i_pwdata,
    output logic      [APB_DW-1:0] o_prdata,
    output logic                   o_pready,
    output logic      [CNT_W-1:0]  o_slot_count
);

    logic [CNT_W-1:0] r_slot_count;
    logic             w_sel_count;

    // Registers sit at 4-byte strides, so bit 2 selects the register.
    assign w_sel_count = (i_paddr[APB_AW-1] == REG_SLOT_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= COUNT_RESET;
        end else if (i_psel && i_penable && i_pwrite && w_sel_count) begin
            r_slot_count <= i_pwdata[CNT_W-1:0];
        end
    end

    assign o_prdata     = w_sel_count ? APB_DW'(r_slot_count) : '0;
    assign o_pready     = 1'b1;
    assign o_slot_count = r_slot_count;

endmodule : cffsa_apb_regs

`default_nettype wire

/* hdl/cffsa_slot_map.sv */
// Occupancy bitmap of the slot allocator with its rotated first-free search.
// Depends on cffsa_pkg.
`default_nettype none

module cffsa_slot_map
    import cffsa_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CNT_W-1:0] i_slot_count,
    input  wire t_req             i_req,
    output t_grant                o_grant
);

    // Slot fields are 8 bits wide, so no more than 256 slots can be reached.
    localparam int NUM_SLOTS = (MAX_SLOTS < SLOT_REACH) ? MAX_SLOTS : SLOT_REACH;
    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam logic [NUM_SLOTS-1:0] ALL_ONES = {NUM_SLOTS{1'b1}};

    logic [NUM_SLOTS-1:0] r_occ;
    logic [NUM_SLOTS-1:0] n_occ;

    logic [CNT_W-1:0]     w_count;
    logic [SLOT_W-1:0]    w_start;
    logic [NUM_SLOTS-1:0] w_in_range;
    logic [NUM_SLOTS-1:0] w_free;
    logic [NUM_SLOTS-1:0] w_free_hi;
    logic [NUM_SLOTS-1:0] w_pick;
    logic [NUM_SLOTS-1:0] w_onehot;
    logic [NUM_SLOTS-1:0] w_rel_mask;
    logic [IDX_W-1:0]     w_enc;
    logic                 w_full;

    assign w_count = (i_slot_count > CNT_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS) : i_slot_count;

    // A start slot outside the active range begins the search at slot 0.
    assign w_start = ({1'b0, i_req.slot} < w_count) ? i_req.slot : '0;

    assign w_in_range = ~(ALL_ONES << w_count);
    assign w_free     = ~r_occ & w_in_range;
    assign w_free_hi  = w_free & (ALL_ONES << w_start);
    assign w_full     = ~|w_free;

    // Free slots at or above the start win; otherwise wrap to the lowest free slot.
    assign w_pick   = (|w_free_hi) ? w_free_hi : w_free;
    assign w_onehot = w_pick & (~w_pick + NUM_SLOTS'(1));

    always_comb begin
        w_enc = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            w_enc = w_enc | ({IDX_W{w_onehot[i]}} & IDX_W'(i));
        end
    end

    assign w_rel_mask = (NUM_SLOTS'(1) << i_req.slot) & w_in_range;

    always_comb begin
        n_occ = r_occ;
        if (i_req.fire) begin
            if (i_req.op == OP_ALLOC) begin
                n_occ = r_occ | w_onehot;
            end else begin
                n_occ = r_occ & ~w_rel_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign o_grant.slot = SLOT_W'(w_enc);
    assign o_grant.full = w_full;

    // A successful allocation leaves the granted slot marked occupied.
    a_grant_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.fire && i_req.op == OP_ALLOC && !w_full)
            |=> ((r_occ & $past(w_onehot)) == $past(w_onehot)))
        else $error("granted slot not marked occupied");

    // A release can only clear marks, never set one.
    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.fire && i_req.op == OP_RELEASE)
            |=> ((r_occ & ~$past(r_occ)) == '0))
        else $error("release set an occupancy mark");

    // An allocation sets exactly one mark unless the store is full.
    a_alloc_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.fire && i_req.op == OP_ALLOC)
            |=> ($countones(r_occ) == $countones($past(r_occ)) + ($past(w_full) ? 0 : 1)))
        else $error("allocation changed the wrong number of marks");

    // Without an executed request the bitmap holds.
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.fire |=> $stable(r_occ))
        else $error("occupancy changed without a request");

endmodule : cffsa_slot_map

`default_nettype wire

/* hdl/circular_first_free_slot_allocator_core.sv */
// Top level of the circular first-free slot allocator.
// Depends on cffsa_pkg, cffsa_apb_regs and cffsa_slot_map.
//
//  Channel  | Direction | Payload                                   | Handshake
//  ---------+-----------+-------------------------------------------+-------------------
//  s_*      | in        | tdata = slot, tuser = operation           | tvalid / tready
//  m_*      | out       | tdata = granted_slot, tuser = full_res    | tvalid / tready
//  APB      | in/out    | slot_count register at byte address 0     | psel/penable, pready=1
//
// One word is accepted per cycle while the slave side is ready. An accepted word is
// registered in the input register and executed by a combinational rotated priority
// search over the occupancy bitmap; an allocate result is registered in the output
// register and offered on the master side. Releases give no result word. Reset is
// synchronous and active low; it empties the pipeline and marks every slot free at
// once, with no clearing pass. When the master side stalls, a pending allocate waits
// in the input register and the slave side stays ready only while that register is empty.
`default_nettype none

module circular_first_free_slot_allocator_core
    import cffsa_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [SLOT_W-1:0] s_tdata,    // [7:0] slot
    input  wire logic              s_tuser,    // [0] operation

    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [SLOT_W-1:0] m_tdata,    // [7:0] granted_slot
    output logic                   m_tuser,    // [0] full_res

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    logic [CNT_W-1:0]  w_slot_count;

    // Input register: the word waiting to be executed against the bitmap.
    logic              r_in_valid;
    logic              r_in_op;
    logic [SLOT_W-1:0] r_in_slot;

    // Output register: the result word offered on the master side.
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_full;

    logic              w_fire;
    logic              w_out_free;
    t_req              w_req;
    t_grant            w_grant;

    cffsa_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_prdata     (prdata),
        .o_pready     (pready),
        .o_slot_count (w_slot_count)
    );

    // The output register can take a new result if it is empty or being drained.
    assign w_out_free = !r_out_valid || m_tready;

    // A release needs no output space; an allocate does.
    assign w_fire = r_in_valid && ((r_in_op == OP_RELEASE) || w_out_free);

    assign s_tready = !r_in_valid || w_fire;

    assign w_req.fire = w_fire;
    assign w_req.op   = r_in_op;
    assign w_req.slot = r_in_slot;

    cffsa_slot_map #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_slot_count (w_slot_count),
        .i_req        (w_req),
        .o_grant      (w_grant)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_op   <= s_tuser;
            r_in_slot <= s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && (r_in_op == OP_ALLOC)) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && (r_in_op == OP_ALLOC)) begin
            r_out_slot <= w_grant.slot;
            r_out_full <= w_grant.full;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_slot;
    assign m_tuser  = r_out_full;

endmodule : circular_first_free_slot_allocator_core

`default_nettype wire
